// File: sv/pgfs_pkg.sv
// ----------------------------------------------------------------------------
// pgfs_pkg: shared types and constants for the PCM gain/fade block
// Sequencer state codes, register indexes, gain format and divider status.
// ----------------------------------------------------------------------------
package pgfs_pkg;

  // Gain register format: unsigned Q15, 32768 is unity
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned UNITY_SHIFT = 15;

  // Configuration port
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q15    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH = 1'd1;

  localparam logic [GAIN_W-1:0]     GAIN_RESET = 16'd32768;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_GAIN  = 6'b000010,
    S_SCALE = 6'b000100,
    S_DLOAD = 6'b001000,
    S_DWAIT = 6'b010000,
    S_FIN   = 6'b100000
  } seq_state_e;

  // Status of the serial divider towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/pgfs_div.sv
// ----------------------------------------------------------------------------
// pgfs_div: serial restoring divider
// One quotient bit per cycle. The caller guarantees the quotient fits in
// QUOT_W bits, so the division starts from the top DIVS_W dividend bits.
// ----------------------------------------------------------------------------
module pgfs_div #(
  parameter int unsigned QUOT_W = 16,
  parameter int unsigned DIVS_W = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [QUOT_W+DIVS_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0]        divisor_i,   // held stable while busy
  output logic [QUOT_W-1:0]        quotient_o,
  output pgfs_pkg::div_stat_t      stat_o
);
  import pgfs_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0] bits_q, bits_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DIVS_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, bits_q[QUOT_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    bits_d = bits_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[QUOT_W+DIVS_W-1:QUOT_W];
      bits_d = dividend_i[QUOT_W-1:0];
      cnt_d  = CNT_W'(QUOT_W);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? DIVS_W'(trial - {1'b0, divisor_i}) : trial[DIVS_W-1:0];
      bits_d = {bits_q[QUOT_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
  end

  assign quotient_o  = bits_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

// File: sv/pcm_gain_fade_saturate.sv
// ----------------------------------------------------------------------------
// pcm_gain_fade_saturate: Q15 gain with linear fade-out and saturation
// Scales each sample by the gain register, applies a running fade-out
// (sample * remaining / total) and saturates to the sample width.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: pcm_in, tuser: start_fade,
//                                                     tlast: frame_last
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: pcm_out, tlast: out_frame_last
// cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Without fade a sample passes S_GAIN, S_SCALE and S_FIN before it reaches the
// output register; with fade it passes S_GAIN, S_SCALE, S_DLOAD, S_DWAIT and
// S_FIN, where S_DWAIT waits for the serial divider (one quotient bit a cycle).
// One multiplier serves both multiplies. The input is ready only in idle; a
// result waits in the output register, so the next sample can enter first.
// Reset restores unity gain, zero fade length and clears both counters.
//
module pcm_gain_fade_saturate #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FADE_WIDTH   = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // tdata: pcm_in [SAMPLE_WIDTH-1:0], zero pad above
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  // tuser: start_fade [0]
  input  logic                                     s_axis_tuser,
  input  logic                                     s_axis_tlast,
  // tdata: pcm_out [SAMPLE_WIDTH-1:0], zero pad above
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  output logic                                     m_axis_tlast,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [pgfs_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [pgfs_pkg::CFG_DATA_W-1:0]          cfg_data_i
);
  import pgfs_pkg::*;

  localparam int unsigned TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned MB_W    = (FADE_WIDTH > GAIN_W) ? FADE_WIDTH : GAIN_W;
  localparam int unsigned PROD_W  = SAMPLE_WIDTH + MB_W;

  localparam logic [SAMPLE_WIDTH-1:0] LIM_NEG = SAMPLE_WIDTH'(1) << (SAMPLE_WIDTH - 1);
  localparam logic [SAMPLE_WIDTH-1:0] LIM_POS = LIM_NEG - SAMPLE_WIDTH'(1);

  seq_state_e              state_q, state_d;
  logic [GAIN_W-1:0]       gain_q;
  logic [CFG_DATA_W-1:0]   fade_len_q;
  logic [FADE_WIDTH-1:0]   total_q, total_d;
  logic [FADE_WIDTH-1:0]   left_q, left_d;
  logic                    neg_q;
  logic                    last_q;
  logic [SAMPLE_WIDTH-1:0] mag_q;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [SAMPLE_WIDTH-1:0] res_q, res_d;
  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_data_q;
  logic                    out_last_q;

  logic [SAMPLE_WIDTH-1:0] in_sample;
  logic                    in_accept;
  logic                    out_free;
  logic [MB_W-1:0]         mul_b;
  logic [PROD_W-1:0]       mul_res;
  logic [SAMPLE_WIDTH-1:0] gained;
  logic                    fading;
  logic                    div_start;
  logic [SAMPLE_WIDTH-1:0] quot;
  div_stat_t               div_stat;
  logic [SAMPLE_WIDTH-1:0] sat_val;

  assign in_sample     = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GAIN_RESET;
      fade_len_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GAIN_Q15:    gain_q     <= cfg_data_i;
        REG_FADE_LENGTH: fade_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared multiplier: gain in the first pass, fade remaining in the second
  assign mul_b   = (state_q == S_GAIN) ? MB_W'(gain_q) : MB_W'(left_q);
  assign mul_res = PROD_W'((state_q == S_GAIN) ? mag_q : gained) * PROD_W'(mul_b);
  assign gained  = prod_q[UNITY_SHIFT +: SAMPLE_WIDTH];
  assign fading  = (left_q != '0) && (total_q != '0);

  pgfs_div #(
    .QUOT_W (SAMPLE_WIDTH),
    .DIVS_W (FADE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[SAMPLE_WIDTH+FADE_WIDTH-1:0]),
    .divisor_i  (total_q),
    .quotient_o (quot),
    .stat_o     (div_stat)
  );

  assign div_start = (state_q == S_DLOAD);

  // Saturate the magnitude with its sign
  always_comb begin
    if (neg_q) begin
      sat_val = (res_q > LIM_NEG) ? LIM_NEG : res_q;
      sat_val = SAMPLE_WIDTH'(~sat_val + SAMPLE_WIDTH'(1));
    end else begin
      sat_val = (res_q > LIM_POS) ? LIM_POS : res_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    total_d = total_q;
    left_d  = left_q;
    prod_d  = prod_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_GAIN;
          if (s_axis_tuser) begin
            total_d = FADE_WIDTH'(fade_len_q);
            left_d  = FADE_WIDTH'(fade_len_q);
          end
        end
      end
      S_GAIN: begin
        prod_d  = mul_res;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        if (fading) begin
          prod_d  = mul_res;
          state_d = S_DLOAD;
        end else begin
          // zero once the fade has run out
          res_d   = (total_q != '0) ? '0 : gained;
          state_d = S_FIN;
        end
      end
      S_DLOAD: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_stat.done) begin
          res_d   = quot;
          left_d  = left_q - FADE_WIDTH'(1);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (last_q && (left_q == '0)) begin
            total_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      left_q  <= left_d;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    res_q  <= res_d;
    if (in_accept) begin
      neg_q  <= in_sample[SAMPLE_WIDTH-1];
      mag_q  <= in_sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(~in_sample + SAMPLE_WIDTH'(1))
                                         : in_sample;
      last_q <= s_axis_tlast;
    end
    if (state_q == S_FIN && out_free) begin
      out_data_q <= sat_val;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);
  assign m_axis_tlast  = out_last_q;

  // The remaining count never runs ahead of the total
  a_left_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= total_q)
    else $error("fade remaining exceeds fade total");

  // Divider completes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DWAIT))
    else $error("divider finished outside its wait state");

  // An accepted transaction starts the gain multiply next
  a_accept_to_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_GAIN))
    else $error("accepted sample did not enter gain stage");

  // The divider is never launched while already busy
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule
